// ----- sv/pld_pkg.sv -----
// Package: shared types and constants of the posting list decoder.
package pld_pkg;

  localparam logic [31:0] END_DOC = 32'd2147483647;

  localparam logic [1:0] STATUS_RANGE = 2'd0;
  localparam logic [1:0] STATUS_END   = 2'd1;
  localparam logic [1:0] STATUS_BAD   = 2'd2;

  localparam int unsigned LOW_BITS = 5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
    logic       list_start;
  } pld_in_t;

  typedef struct packed {
    logic [31:0] doc_first;
    logic [31:0] doc_last;
    logic [29:0] within_doc_freq;
    logic [1:0]  status;
  } pld_out_t;

  typedef enum logic [1:0] {
    PH_CODE,
    PH_DELTA1,
    PH_DELTA2
  } pld_phase_e;

  typedef enum logic [2:0] {
    TOK_SINGLE,  // first delta of an even code: one-document range
    TOK_FIRST,   // first delta of an odd code: range start only
    TOK_SECOND,  // second delta: range end
    TOK_END,     // terminator
    TOK_BAD      // malformed code word
  } pld_op_e;

  typedef struct packed {
    pld_op_e     op;
    logic        clr;   // list restarted since the previous token
    logic [31:0] val;
    logic [29:0] wdf;
  } pld_tok_t;

endpackage

// ----- sv/pld_front.sv -----
// Front end: integer assembly, code word classification, skip and end handling.
module pld_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  pld_pkg::pld_in_t in_data_i,
  output logic             tok_wr_o,
  output pld_pkg::pld_tok_t tok_o
);
  import pld_pkg::*;

  pld_phase_e  phase_q, phase_d;
  logic [2:0]  ebl_q, ebl_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] code_q, code_d;
  logic        skip_q, skip_d;
  logic        done_q, done_d;
  logic        clr_q, clr_d;

  // state as seen by this byte, after list restart and skip release
  pld_phase_e  ph_cur;
  logic [2:0]  ebl_cur;
  logic [31:0] acc_cur;
  logic [31:0] code_cur;
  logic        skip_cur;
  logic        done_cur;
  logic        live;

  logic        int_done;
  logic [31:0] val;
  logic [31:0] acc_new;
  logic [2:0]  ebl_new;
  logic [30:0] wdf_full;
  logic        lst, blk;
  logic [7:0]  b;

  assign lst = in_data_i.list_start;
  assign blk = in_data_i.block_start;
  assign b   = in_data_i.data_byte;

  // byte assembler
  always_comb begin
    ph_cur   = lst ? PH_CODE : phase_q;
    ebl_cur  = lst ? 3'd0 : ebl_q;
    acc_cur  = lst ? 32'd0 : acc_q;
    code_cur = lst ? 32'd0 : code_q;
    skip_cur = lst ? 1'b0 : skip_q;
    done_cur = lst ? 1'b0 : done_q;
    live     = !done_cur && (!skip_cur || blk);
    if (!done_cur && skip_cur && blk) begin
      skip_cur = 1'b0;
      ph_cur   = PH_CODE;
      ebl_cur  = 3'd0;
    end
    int_done = 1'b0;
    val      = 32'd0;
    acc_new  = acc_cur;
    ebl_new  = ebl_cur;
    if (ebl_cur != 3'd0) begin
      acc_new  = {acc_cur[23:0], b};
      ebl_new  = ebl_cur - 3'd1;
      int_done = (ebl_new == 3'd0);
      val      = acc_new;
    end else if (!b[7]) begin
      int_done = 1'b1;
      val      = {24'd0, b};
    end else begin
      acc_new = {27'd0, b[LOW_BITS-1:0]};
      ebl_new = b[7:LOW_BITS] - 3'd3;
    end
  end

  // field phase next state
  always_comb begin
    phase_d = phase_q;
    if (take_i) begin
      phase_d = ph_cur;
      if (live && int_done) begin
        case (ph_cur)
          PH_DELTA1: phase_d = code_cur[0] ? PH_DELTA2 : PH_CODE;
          PH_DELTA2: phase_d = PH_CODE;
          default:   phase_d = (val[31:3] != 29'd0) ? PH_DELTA1 : PH_CODE;
        endcase
      end
    end
  end

  assign wdf_full = code_cur[31:1] - 31'd4;

  // token issue and remaining state
  always_comb begin
    tok_wr_o     = 1'b0;
    tok_o.op     = TOK_BAD;
    tok_o.clr    = lst || clr_q;
    tok_o.val    = val;
    tok_o.wdf    = wdf_full[29:0];
    ebl_d        = ebl_q;
    acc_d        = acc_q;
    code_d       = code_q;
    skip_d       = skip_q;
    done_d       = done_q;
    clr_d        = clr_q;
    if (take_i) begin
      ebl_d  = ebl_cur;
      acc_d  = acc_cur;
      code_d = code_cur;
      skip_d = skip_cur;
      done_d = done_cur;
      if (live) begin
        ebl_d = ebl_new;
        acc_d = acc_new;
        if (int_done) begin
          case (ph_cur)
            PH_DELTA1: begin
              tok_wr_o = 1'b1;
              tok_o.op = code_cur[0] ? TOK_FIRST : TOK_SINGLE;
            end
            PH_DELTA2: begin
              tok_wr_o = 1'b1;
              tok_o.op = TOK_SECOND;
            end
            default: begin
              if (val == 32'd0) begin
                tok_wr_o = 1'b1;
                tok_o.op = TOK_END;
                done_d   = 1'b1;
              end else if (val == 32'd2) begin
                skip_d = 1'b1;
              end else if (val == 32'd3) begin
                // no-op code word
              end else if (val[31:3] == 29'd0) begin
                tok_wr_o = 1'b1;
                tok_o.op = TOK_BAD;
              end else begin
                code_d = val;
              end
            end
          endcase
        end
      end
      clr_d = (lst || clr_q) && !tok_wr_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CODE;
      ebl_q   <= 3'd0;
      acc_q   <= 32'd0;
      code_q  <= 32'd0;
      skip_q  <= 1'b0;
      done_q  <= 1'b0;
      clr_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      ebl_q   <= ebl_d;
      acc_q   <= acc_d;
      code_q  <= code_d;
      skip_q  <= skip_d;
      done_q  <= done_d;
      clr_q   <= clr_d;
    end
  end

  // an integer is never still owed extra bytes while waiting for a block start
  a_skip_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> (phase_q == PH_CODE && ebl_q == 3'd0))
    else $error("pld_front: skip with integer in progress");

  // terminator always leaves the assembler at a code word boundary
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (phase_q == PH_CODE && ebl_q == 3'd0 && !skip_q))
    else $error("pld_front: list done with decode in progress");

  // extra byte count never exceeds four
  a_ebl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ebl_q <= 3'd4)
    else $error("pld_front: extra byte count out of range");

endmodule

// ----- sv/pld_fifo.sv -----
// Two-entry token queue between the front end and the back end.
module pld_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  pld_pkg::pld_tok_t wr_data_i,
  output logic              full_o,
  input  logic              rd_i,
  output pld_pkg::pld_tok_t rd_data_o,
  output logic              empty_o
);
  import pld_pkg::*;

  pld_tok_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign wr_en     = wr_i && !full_o;
  assign rd_en     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("pld_fifo: count overflow");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pld_fifo: pointers disagree with count");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("pld_fifo: write while full");

endmodule

// ----- sv/pld_back.sv -----
// Back end: delta accumulation and result register.
module pld_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_valid_i,
  input  pld_pkg::pld_tok_t tok_i,
  output logic              tok_rd_o,
  output logic              empty_o,
  input  logic              pop_i,
  output pld_pkg::pld_out_t out_data_o
);
  import pld_pkg::*;

  logic [31:0] prev_end_q, prev_end_d;
  logic [31:0] range_first_q, range_first_d;
  pld_out_t    out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic [31:0] base, add_a, sum;

  assign out_free = !out_valid_q || pop_i;
  // a range start token produces nothing, so it never waits on the output
  assign tok_rd_o = tok_valid_i && (out_free || tok_i.op == TOK_FIRST);

  assign base  = tok_i.clr ? 32'd0 : prev_end_q;
  assign add_a = (tok_i.op == TOK_SECOND) ? range_first_q : base;
  assign sum   = add_a + tok_i.val;

  always_comb begin
    prev_end_d    = prev_end_q;
    range_first_d = range_first_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !pop_i;
    if (tok_rd_o) begin
      prev_end_d = base;
      case (tok_i.op)
        TOK_SINGLE: begin
          prev_end_d    = sum;
          range_first_d = sum;
          out_d         = '{doc_first: sum, doc_last: sum,
                            within_doc_freq: tok_i.wdf, status: STATUS_RANGE};
          out_valid_d   = 1'b1;
        end
        TOK_FIRST: begin
          range_first_d = sum;
        end
        TOK_SECOND: begin
          prev_end_d  = sum;
          out_d       = '{doc_first: range_first_q, doc_last: sum,
                          within_doc_freq: tok_i.wdf, status: STATUS_RANGE};
          out_valid_d = 1'b1;
        end
        TOK_END: begin
          out_d       = '{doc_first: END_DOC, doc_last: END_DOC,
                          within_doc_freq: 30'd0, status: STATUS_END};
          out_valid_d = 1'b1;
        end
        default: begin
          out_d       = '{doc_first: 32'd0, doc_last: 32'd0,
                          within_doc_freq: 30'd0, status: STATUS_BAD};
          out_valid_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_end_q    <= 32'd0;
      range_first_q <= 32'd0;
      out_valid_q   <= 1'b0;
    end else begin
      prev_end_q    <= prev_end_d;
      range_first_q <= range_first_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == STATUS_END) |->
      (out_q.doc_first == END_DOC && out_q.doc_last == END_DOC &&
       out_q.within_doc_freq == 30'd0))
    else $error("pld_back: bad end-of-list fields");

  a_bad_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == STATUS_BAD) |->
      (out_q.doc_first == 32'd0 && out_q.doc_last == 32'd0 &&
       out_q.within_doc_freq == 30'd0))
    else $error("pld_back: bad malformed-code fields");

  a_range_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_rd_o && tok_i.op != TOK_FIRST) |=> (out_valid_q && prev_end_q ==
      ((out_q.status == STATUS_RANGE) ? out_q.doc_last : $past(base))))
    else $error("pld_back: previous end not tracked");

endmodule

// ----- sv/posting_list_decoder.sv -----
// Top level: delta-coded posting list decoder.
//
// Input channel: one stream byte per transfer with its block_start and
// list_start flags; a transfer happens when push is high and full is low.
// Result channel: one decoded posting range, end-of-list marker or
// malformed-code report; the oldest result sits on out_data_o while empty
// is low and leaves on a cycle with pop high.
// The front end assembles variable-length integers and classifies code
// words; a two-entry token queue feeds the back end, which adds the deltas
// (one 32-bit adder) and holds the result register.
// Throughput: one byte per cycle while full is low. A byte that completes a
// result writes a token into the queue; the back end reads it from there
// into the result register once that register is free. If pop stays low,
// the result register fills first; the queue then takes two more tokens (a
// range start token counts once it waits behind a stalled result) and full
// rises. Bytes that make no token keep flowing until then.
// Reset clears all decode state and empties queue and result register;
// the block takes bytes in the first cycle after reset.
module posting_list_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  pld_pkg::pld_in_t  in_data_i,
  output logic              empty,
  input  logic              pop,
  output pld_pkg::pld_out_t out_data_o
);
  import pld_pkg::*;

  logic     take;
  logic     tok_wr;
  pld_tok_t tok_wr_data;
  logic     tok_rd;
  pld_tok_t tok_rd_data;
  logic     tok_empty;

  assign take = push && !full;

  pld_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_data_i (in_data_i),
    .tok_wr_o  (tok_wr),
    .tok_o     (tok_wr_data)
  );

  pld_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tok_wr),
    .wr_data_i (tok_wr_data),
    .full_o    (full),
    .rd_i      (tok_rd),
    .rd_data_o (tok_rd_data),
    .empty_o   (tok_empty)
  );

  pld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (!tok_empty),
    .tok_i       (tok_rd_data),
    .tok_rd_o    (tok_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_data_o  (out_data_o)
  );

endmodule
